@@ rtl/hpq_pkg.sv @@
// Shared types, constants and helper functions for the binary heap priority queue.
package hpq_pkg;

	localparam int DEPTH       = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_W      = $clog2(DEPTH + 1);
	localparam int FIELD_W     = 32;
	localparam int COUNT_W     = 9;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [ADDR_W-1:0]      addr_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [FIELD_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] popped_value;
		logic [FIELD_W-1:0] top_value;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
	} rsp_t;

	// One write and two reads per cycle on the heap memory.
	typedef struct packed {
		logic   we;
		addr_t  waddr;
		value_t wdata;
		addr_t  raddr0;
		addr_t  raddr1;
	} mem_req_t;

	// Heap slots are 1-based; the memory is 0-based.
	function automatic addr_t slot2addr(input logic [SLOT_W+1:0] slot);
		logic [SLOT_W+1:0] a;
		a = slot - 1'b1;
		return a[ADDR_W-1:0];
	endfunction

	// True when a has strictly higher priority than b.
	function automatic logic better(input value_t a, input value_t b, input logic order_max);
		return order_max ? (a > b) : (a < b);
	endfunction

endpackage

@@ rtl/hpq_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
module hpq_ram #(
	parameter int DEPTH_P = 256,
	parameter int WIDTH_P = 32,
	parameter int ADDR_WP = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_WP-1:0] waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic [ADDR_WP-1:0] raddr0,
	input  logic [ADDR_WP-1:0] raddr1,
	output logic [WIDTH_P-1:0] rdata0,
	output logic [WIDTH_P-1:0] rdata1
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

@@ rtl/hpq_core.sv @@
// Heap sequencer: sift-up and sift-down walks over the heap memory.
module hpq_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             order_max,
	input  logic             req_valid,
	output logic             req_ready,
	input  hpq_pkg::req_t    req,
	output logic             res_valid,
	input  logic             res_take,
	output hpq_pkg::rsp_t    res,
	output hpq_pkg::mem_req_t mem,
	input  hpq_pkg::value_t  rdata0,
	input  hpq_pkg::value_t  rdata1
);
	import hpq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_POP_LD = 6'b000010,
		S_UP_CMP = 6'b000100,
		S_DN_CMP = 6'b001000,
		S_FIN    = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	slot_t   count_q, count_d;
	slot_t   hole_q, hole_d;
	value_t  val_q, val_d;
	status_t status_q, status_d;
	value_t  popped_q, popped_d;
	value_t  root_q;

	logic [SLOT_W+1:0] wslot;
	logic [SLOT_W+1:0] hole_x;
	logic [SLOT_W+1:0] count_x;
	logic [SLOT_W+1:0] child_l;
	logic [SLOT_W+1:0] child_r;
	logic [SLOT_W+1:0] pick_slot;
	logic [SLOT_W+1:0] grand;
	logic [SLOT_W+1:0] parent;
	logic              pick_right;
	value_t            pick_val;

	assign hole_x     = {2'b00, hole_q};
	assign count_x    = {2'b00, count_q};
	assign child_l    = {hole_x[SLOT_W:0], 1'b0};
	assign child_r    = child_l + 1'b1;
	assign pick_right = (child_r <= count_x) && better(rdata1, rdata0, order_max);
	assign pick_val   = pick_right ? rdata1 : rdata0;
	assign pick_slot  = pick_right ? child_r : child_l;
	assign grand      = {pick_slot[SLOT_W:0], 1'b0};
	assign parent     = hole_x >> 1;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		hole_d     = hole_q;
		val_d      = val_q;
		status_d   = status_q;
		popped_d   = popped_q;
		mem.we     = 1'b0;
		wslot      = hole_x;
		mem.wdata  = val_q;
		mem.raddr0 = '0;
		mem.raddr1 = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					status_d = ST_OK;
					popped_d = '0;
					if (req.cmd == CMD_PUSH) begin
						if (count_x >= (SLOT_W+2)'(DEPTH)) begin
							status_d = ST_FULL;
							state_d  = S_RESP;
						end else begin
							count_d = count_q + 1'b1;
							hole_d  = count_q + 1'b1;
							val_d   = req.value[VALUE_WIDTH-1:0];
							if (count_q == '0) begin
								state_d = S_FIN;
							end else begin
								mem.raddr0 = slot2addr((count_x + 1'b1) >> 1);
								state_d    = S_UP_CMP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_RESP;
						end else begin
							popped_d   = root_q;
							count_d    = count_q - 1'b1;
							mem.raddr0 = slot2addr(count_x);
							state_d    = (count_q == SLOT_W'(1)) ? S_RESP : S_POP_LD;
						end
					end
				end
			end
			S_POP_LD: begin
				val_d  = rdata0;
				hole_d = SLOT_W'(1);
				if (count_q == SLOT_W'(1)) begin
					state_d = S_FIN;
				end else begin
					mem.raddr0 = slot2addr((SLOT_W+2)'(2));
					mem.raddr1 = slot2addr((SLOT_W+2)'(3));
					state_d    = S_DN_CMP;
				end
			end
			S_UP_CMP: begin
				if (better(val_q, rdata0, order_max)) begin
					mem.we     = 1'b1;
					mem.wdata  = rdata0;
					hole_d     = parent[SLOT_W-1:0];
					if (parent == (SLOT_W+2)'(1)) begin
						state_d = S_FIN;
					end else begin
						mem.raddr0 = slot2addr(parent >> 1);
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_CMP: begin
				if (better(pick_val, val_q, order_max)) begin
					mem.we    = 1'b1;
					mem.wdata = pick_val;
					hole_d    = pick_slot[SLOT_W-1:0];
					if (grand > count_x) begin
						state_d = S_FIN;
					end else begin
						mem.raddr0 = slot2addr(grand);
						mem.raddr1 = slot2addr(grand + 1'b1);
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				mem.we  = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		mem.waddr = slot2addr(wslot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// The root is shadowed in a register so every result can report it.
	always_ff @(posedge clk) begin
		hole_q   <= hole_d;
		val_q    <= val_d;
		status_q <= status_d;
		popped_q <= popped_d;
		if (mem.we && (wslot == (SLOT_W+2)'(1))) begin
			root_q <= mem.wdata;
		end
	end

	assign res.status       = status_q;
	assign res.popped_value = FIELD_W'(popped_q);
	assign res.top_value    = (count_q == '0) ? '0 : FIELD_W'(root_q);
	assign res.entry_count  = COUNT_W'(count_q);
	assign res.is_empty     = (count_q == '0);

endmodule

@@ rtl/binary_heap_priority_queue.sv @@
// Binary heap priority queue top level: order register, heap RAM, sequencer, output register.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_ready   req   (cmd, value)
//  rsp      out        rsp_valid/rsp_ready   rsp   (status, popped_value, top_value,
//                                                   entry_count, is_empty)
//  cfg      in         cfg_we                cfg_wdata (order_max)
//
// One transfer on req is handled at a time. A push climbs and a pop sinks one level
// per read of the heap RAM, which returns data in the cycle after the address; errors
// and a pop that empties the queue go straight to the result without a sift.
// Reset clears the entry count and the order bit but not the heap RAM, whose unwritten
// slots are never used. While rsp_ready is low the result waits in the output register.
module binary_heap_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hpq_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import hpq_pkg::*;

	logic     order_max_q;
	logic     res_valid;
	logic     res_take;
	rsp_t     res;
	mem_req_t mem;
	value_t   rdata0;
	value_t   rdata1;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	// The order bit selects min-heap (0) or max-heap (1) comparisons. Entries already
	// held are not reordered when it changes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_max_q <= 1'b0;
		end else if (cfg_we) begin
			order_max_q <= cfg_wdata;
		end
	end

	hpq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (VALUE_WIDTH)
	) u_ram (
		.clk    (clk),
		.we     (mem.we),
		.waddr  (mem.waddr),
		.wdata  (mem.wdata),
		.raddr0 (mem.raddr0),
		.raddr1 (mem.raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	hpq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.order_max (order_max_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem       (mem),
		.rdata0    (rdata0),
		.rdata1    (rdata1)
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign res_take = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/hpq_checker.sv @@
// Port-level checker for the binary heap priority queue, bound to the top level.
module hpq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input hpq_pkg::rsp_t rsp
);
	import hpq_pkg::*;

	// A stalled result transfer keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)) &&
		(!rsp.is_empty || rsp.top_value == '0))
		else $error("empty flag, count and top disagree");

	a_err_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0)
		else $error("failed request reports a popped value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= COUNT_W'(DEPTH) &&
		(rsp.status != ST_FULL || rsp.entry_count == COUNT_W'(DEPTH)) &&
		(rsp.status != ST_EMPTY || rsp.is_empty))
		else $error("entry count inconsistent with status");

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ verif/tb_binary_heap_priority_queue.sv @@
// Self-checking testbench for the binary heap priority queue with its own heap predictor.
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;
	import hpq_pkg::*;

	// Cycles the block may still need after its last result. This is the longest
	// sift plus the result register, with some margin.
	localparam int SETTLE_CYCLES = 16;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;
	logic  cfg_we    = 1'b0;
	logic  cfg_wdata = 1'b0;

	binary_heap_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the heap. Slots are 1-based, as in the block.
	value_t heap_slots [1:DEPTH];
	int     heap_fill    = 0;
	bit     order_is_max = 1'b0;

	// Results predicted at each accepted request, oldest first.
	rsp_t   awaited_results [$];

	// Random idling is only allowed while this is set.
	bit     gaps_on = 1'b0;
	int     error_count = 0;
	int     push_count = 0, pop_count = 0, empty_pops = 0, full_pushes = 0, order_writes = 0;

	// True when a must sit above b under the current order. Ties never rank higher,
	// so equal values are never swapped.
	function automatic bit ranks_higher(input value_t a, input value_t b);
		return order_is_max ? (a > b) : (a < b);
	endfunction

	function automatic void swap_slots(input int i, input int j);
		value_t t;
		t = heap_slots[i];
		heap_slots[i] = heap_slots[j];
		heap_slots[j] = t;
	endfunction

	// Applies one command to the shadow heap and returns the result the block must give.
	function automatic rsp_t apply_heap_command(input req_t r);
		rsp_t e;
		int   i;
		int   c;
		e = '0;
		e.status = ST_OK;
		if (r.cmd == CMD_PUSH) begin
			push_count++;
			if (heap_fill >= DEPTH) begin
				// A full queue discards the value and keeps its contents.
				e.status = ST_FULL;
				full_pushes++;
			end else begin
				heap_fill++;
				heap_slots[heap_fill] = r.value[VALUE_WIDTH-1:0];
				i = heap_fill;
				while (i > 1 && ranks_higher(heap_slots[i], heap_slots[i / 2])) begin
					swap_slots(i, i / 2);
					i = i / 2;
				end
			end
		end else begin
			pop_count++;
			if (heap_fill == 0) begin
				e.status = ST_EMPTY;
				empty_pops++;
			end else begin
				// The last entry moves to the root and sinks toward the better
				// child; on equal children the left one wins.
				e.popped_value = heap_slots[1];
				heap_slots[1] = heap_slots[heap_fill];
				heap_fill--;
				i = 1;
				while (2 * i <= heap_fill) begin
					c = 2 * i;
					if (c + 1 <= heap_fill && ranks_higher(heap_slots[c + 1], heap_slots[c]))
						c = c + 1;
					if (!ranks_higher(heap_slots[c], heap_slots[i]))
						break;
					swap_slots(c, i);
					i = c;
				end
			end
		end
		e.top_value   = (heap_fill != 0) ? heap_slots[1] : '0;
		e.entry_count = COUNT_W'(heap_fill);
		e.is_empty    = (heap_fill == 0);
		return e;
	endfunction

	// Mixes full-range values with small ones, for ties, and with the extremes.
	function automatic logic [FIELD_W-1:0] pick_value();
		case ($urandom_range(0, 3)) inside
			[0:1]: return $urandom;
			2: return $urandom_range(0, 7);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
		endcase
	endfunction

	// Response side: rsp_ready drops in random stall bursts while idling is on.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// Every result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				error_count++;
			end else begin
				e = awaited_results.pop_front();
				report_field("status", e.status, rsp.status);
				report_field("popped_value", e.popped_value, rsp.popped_value);
				report_field("top_value", e.top_value, rsp.top_value);
				report_field("entry_count", e.entry_count, rsp.entry_count);
				report_field("is_empty", e.is_empty, rsp.is_empty);
			end
		end
	end

	// Sends one command. An optional idle burst comes first; valid is only lowered
	// there, so a back-to-back command keeps valid high across the transfer edge.
	task automatic send_command(input cmd_t c, input logic [FIELD_W-1:0] v);
		rsp_t want;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{cmd: c, value: v};
		do @(posedge clk); while (!req_ready);
		want = apply_heap_command('{cmd: c, value: v});
		awaited_results = {awaited_results, want};
	endtask

	// Stops sending and waits until the block has nothing left in flight.
	task automatic drain_block();
		req_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The order bit is only written while the block is idle. Entries already held
	// are not reordered; later sifts just compare with the new order.
	task automatic set_order(input bit want_max);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= want_max;
		@(posedge clk);
		cfg_we    <= 1'b0;
		order_is_max = want_max;
		order_writes++;
	endtask

	task automatic random_phase(input int n, input int push_pct);
		repeat (n) begin
			if ($urandom_range(1, 100) <= push_pct)
				send_command(CMD_PUSH, pick_value());
			else
				send_command(CMD_POP, $urandom);
		end
	endtask

	// Smallest-first order: pop on an empty queue, both value extremes, equal values.
	task automatic test_min_order_basics();
		gaps_on = 1'b0;
		set_order(1'b0);
		send_command(CMD_POP, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'd5);
		send_command(CMD_PUSH, 32'd5);
		send_command(CMD_PUSH, 32'd3);
		repeat (5) send_command(CMD_POP, 32'h0);
		send_command(CMD_POP, 32'h0);
	endtask

	// Largest-first order with three equal entries, so the left child wins a tie, then
	// the order flips while five entries are still held.
	task automatic test_max_order_and_flip();
		gaps_on = 1'b1;
		set_order(1'b1);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'h8000_0000);
		send_command(CMD_PUSH, 32'd7);
		send_command(CMD_PUSH, 32'd7);
		send_command(CMD_PUSH, 32'd7);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_POP, 32'h0);
		set_order(1'b0);
		repeat (5) send_command(CMD_POP, 32'h0);
	endtask

	// Fills the heap to its depth, pushes into the full queue, then drains it with an
	// order change halfway.
	task automatic test_fill_to_full();
		gaps_on = 1'b1;
		set_order(bit'($urandom_range(0, 1)));
		while (heap_fill < DEPTH) send_command(CMD_PUSH, pick_value());
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, $urandom);
		repeat (DEPTH / 2) send_command(CMD_POP, $urandom);
		set_order(!order_is_max);
		while (heap_fill > 0) send_command(CMD_POP, $urandom);
		send_command(CMD_POP, $urandom);
	endtask

	// Phases that alternately grow and shrink the heap, with a random order each
	// phase and one phase without idling.
	task automatic test_random_mix();
		for (int ph = 0; ph < 5; ph++) begin
			set_order(bit'($urandom_range(0, 1)));
			gaps_on = (ph != 2);
			random_phase(100, (ph % 2 == 0) ? 70 : 35);
		end
	endtask

	// The closing stretch runs with no idling on either side.
	task automatic test_back_to_back();
		set_order(bit'($urandom_range(0, 1)));
		gaps_on = 1'b0;
		random_phase(110, 55);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_min_order_basics();
		test_max_order_and_flip();
		test_fill_to_full();
		test_random_mix();
		test_back_to_back();
		drain_block();
		$display("Ran %0d pushes and %0d pops, %0d into a full queue and %0d on an empty one,",
			push_count, pop_count, full_pushes, empty_pops);
		$display("across %0d writes of the order bit, with and without idling.", order_writes);
		if (error_count == 0 && awaited_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// The slowest correct run stays well under a tenth of this.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_core.sv
rtl/binary_heap_priority_queue.sv
rtl/hpq_checker.sv
verif/tb_binary_heap_priority_queue.sv
